### rtl/ipv4_receive_header_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// IPv4 receive header filter assertion macros
// Concurrent assertion helpers for simulation. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef IPV4_RECEIVE_HEADER_FILTER_UNIT_MACROS_SVH
`define IPV4_RECEIVE_HEADER_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IHF_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("IPv4 header filter check failed");
`define IHF_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("IPv4 header filter check failed");
`else
`define IHF_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define IHF_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

### rtl/ihf_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter package
// Transaction types, verdict codes and header constants.
// ----------------------------------------------------------------------------
package ihf_pkg;

  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS       = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BROADCAST_ADDRESS = 1'd1;

  localparam logic [2:0] VERDICT_ACCEPTED          = 3'd0;
  localparam logic [2:0] VERDICT_WRONG_DESTINATION = 3'd1;
  localparam logic [2:0] VERDICT_FRAGMENT          = 3'd2;
  localparam logic [2:0] VERDICT_CHECKSUM_BAD      = 3'd3;
  localparam logic [2:0] VERDICT_TRUNCATED         = 3'd4;

  localparam logic [5:0]  MIN_HEADER_BYTES = 6'd20;
  localparam logic [15:0] CHECKSUM_GOOD    = 16'hFFFF;
  localparam int          MF_BIT           = 13;

  localparam logic [5:0] IDX_VERSION_IHL   = 6'd0;
  localparam logic [5:0] IDX_TOTAL_LEN_HI  = 6'd2;
  localparam logic [5:0] IDX_TOTAL_LEN_LO  = 6'd3;
  localparam logic [5:0] IDX_FRAG_HI       = 6'd6;
  localparam logic [5:0] IDX_FRAG_LO       = 6'd7;
  localparam logic [5:0] IDX_TTL           = 6'd8;
  localparam logic [5:0] IDX_PROTOCOL      = 6'd9;
  localparam logic [5:0] IDX_SOURCE_FIRST  = 6'd12;
  localparam logic [5:0] IDX_SOURCE_LAST   = 6'd15;
  localparam logic [5:0] IDX_DEST_FIRST    = 6'd16;
  localparam logic [5:0] IDX_DEST_LAST     = 6'd19;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [15:0] payload_length;
    logic [5:0]  header_bytes;
    logic [7:0]  ttl_after;
  } result_item_t;

  typedef struct packed {
    logic        truncated;
    logic [31:0] source;
    logic [31:0] destination;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [5:0]  header_bytes;
    logic [15:0] fragment_info;
    logic [7:0]  ttl;
    logic [15:0] checksum_sum;
  } header_entry_t;

endpackage

### rtl/ihf_fifo.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter queue
// Short register queue of captured headers between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module ihf_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ihf_pkg::header_entry_t push_entry,
  input  logic                   pop,
  output ihf_pkg::header_entry_t head,
  output logic                   head_valid,
  output logic                   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ihf_pkg::header_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/ihf_front.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter parser
// Takes one byte per transaction, captures header fields, keeps the ones'
// complement sum and queues a header entry when the header or packet ends.
// ----------------------------------------------------------------------------
module ihf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  input  ihf_pkg::byte_item_t    byte_item,
  input  logic                   queue_full,
  output logic                   byte_stall,
  output logic                   push,
  output ihf_pkg::header_entry_t push_entry
);

  logic [5:0]  byte_index;
  logic [15:0] sum;
  logic [7:0]  odd_byte_hold;
  logic [5:0]  header_length;
  logic [15:0] total_length;
  logic [15:0] fragment_info;
  logic [7:0]  ttl;
  logic [7:0]  protocol;
  logic [31:0] source;
  logic [31:0] destination;
  logic        verdict_given;

  logic [15:0] sum_next;
  logic [5:0]  header_length_next;
  logic [15:0] total_length_next;
  logic [15:0] fragment_info_next;
  logic [7:0]  ttl_next;
  logic [7:0]  protocol_next;
  logic [31:0] source_next;
  logic [31:0] destination_next;
  logic [16:0] word_sum;
  logic [5:0]  ihl_bytes;
  logic [7:0]  b;
  logic        accept;
  logic        active;
  logic        complete;
  logic        truncated;

  assign b          = byte_item.packet_byte;
  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;
  assign active     = accept && !verdict_given;
  assign ihl_bytes  = {b[3:0], 2'b00};

  always_comb begin
    header_length_next = header_length;
    total_length_next  = total_length;
    fragment_info_next = fragment_info;
    ttl_next           = ttl;
    protocol_next      = protocol;
    source_next        = source;
    destination_next   = destination;
    if (byte_index == ihf_pkg::IDX_VERSION_IHL) begin
      header_length_next = (ihl_bytes < ihf_pkg::MIN_HEADER_BYTES) ?
                           ihf_pkg::MIN_HEADER_BYTES : ihl_bytes;
    end
    if (byte_index == ihf_pkg::IDX_TOTAL_LEN_HI || byte_index == ihf_pkg::IDX_TOTAL_LEN_LO) begin
      total_length_next = {total_length[7:0], b};
    end
    if (byte_index == ihf_pkg::IDX_FRAG_HI || byte_index == ihf_pkg::IDX_FRAG_LO) begin
      fragment_info_next = {fragment_info[7:0], b};
    end
    if (byte_index == ihf_pkg::IDX_TTL) begin
      ttl_next = b;
    end
    if (byte_index == ihf_pkg::IDX_PROTOCOL) begin
      protocol_next = b;
    end
    if (byte_index >= ihf_pkg::IDX_SOURCE_FIRST && byte_index <= ihf_pkg::IDX_SOURCE_LAST) begin
      source_next = {source[23:0], b};
    end
    if (byte_index >= ihf_pkg::IDX_DEST_FIRST && byte_index <= ihf_pkg::IDX_DEST_LAST) begin
      destination_next = {destination[23:0], b};
    end
  end

  always_comb begin
    word_sum = {1'b0, sum} + {1'b0, odd_byte_hold, b};
    sum_next = sum;
    if (byte_index[0]) begin
      sum_next = word_sum[15:0] + {15'd0, word_sum[16]};
    end
  end

  assign complete  = active && (byte_index != '0) &&
                     ((byte_index + 6'd1) == header_length);
  assign truncated = active && !complete && byte_item.last_byte;
  assign push      = complete || truncated;

  always_comb begin
    push_entry.truncated     = truncated;
    push_entry.source        = source_next;
    push_entry.destination   = destination_next;
    push_entry.protocol      = protocol_next;
    push_entry.total_length  = total_length_next;
    push_entry.header_bytes  = header_length;
    push_entry.fragment_info = fragment_info_next;
    push_entry.ttl           = ttl_next;
    push_entry.checksum_sum  = sum_next;
  end

  always_ff @(posedge clk) begin
    if (active) begin
      header_length <= header_length_next;
      total_length  <= total_length_next;
      fragment_info <= fragment_info_next;
      ttl           <= ttl_next;
      protocol      <= protocol_next;
      source        <= source_next;
      destination   <= destination_next;
      if (!byte_index[0]) begin
        odd_byte_hold <= b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      sum           <= '0;
      verdict_given <= 1'b0;
    end else if (accept) begin
      if (byte_item.last_byte) begin
        byte_index    <= '0;
        sum           <= '0;
        verdict_given <= 1'b0;
      end else if (active) begin
        byte_index    <= byte_index + 6'd1;
        sum           <= sum_next;
        verdict_given <= complete;
      end
    end
  end

endmodule

### rtl/ihf_back.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter verdict stage
// Holds the address registers, judges a queued header and drives the result
// register.
// ----------------------------------------------------------------------------
module ihf_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ihf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data,
  input  ihf_pkg::header_entry_t              head,
  input  logic                                head_valid,
  output logic                                pop,
  input  logic                                result_stall,
  output logic                                result_valid,
  output ihf_pkg::result_item_t               result_item
);

  logic [31:0] own_address;
  logic [31:0] broadcast_address;
  ihf_pkg::result_item_t result_next;
  logic        wrong_destination;
  logic        fragment;
  logic [15:0] header_len_wide;

  assign pop             = head_valid && (!result_valid || !result_stall);
  assign header_len_wide = {10'd0, head.header_bytes};

  assign wrong_destination = (own_address != '0) && (head.destination != own_address) &&
                             (head.destination != broadcast_address);
  assign fragment          = head.fragment_info[ihf_pkg::MF_BIT] ||
                             (head.fragment_info[12:0] != '0);

  always_comb begin
    result_next = '0;
    if (head.truncated) begin
      result_next.verdict = ihf_pkg::VERDICT_TRUNCATED;
    end else begin
      priority if (wrong_destination) begin
        result_next.verdict = ihf_pkg::VERDICT_WRONG_DESTINATION;
      end else if (fragment) begin
        result_next.verdict = ihf_pkg::VERDICT_FRAGMENT;
      end else if (head.checksum_sum != ihf_pkg::CHECKSUM_GOOD) begin
        result_next.verdict = ihf_pkg::VERDICT_CHECKSUM_BAD;
      end else begin
        result_next.verdict = ihf_pkg::VERDICT_ACCEPTED;
      end
      result_next.source_address      = head.source;
      result_next.destination_address = head.destination;
      result_next.protocol_number     = head.protocol;
      result_next.payload_length      = (head.total_length > header_len_wide) ?
                                        head.total_length - header_len_wide : 16'd0;
      result_next.header_bytes        = head.header_bytes;
      result_next.ttl_after           = (head.ttl != '0) ? head.ttl - 8'd1 : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= '0;
      broadcast_address <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ihf_pkg::CFG_OWN_ADDRESS:       own_address       <= cfg_data;
        ihf_pkg::CFG_BROADCAST_ADDRESS: broadcast_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_item <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

### rtl/ipv4_receive_header_filter_unit.sv
// ----------------------------------------------------------------------------
// IPv4 receive header filter
// Parses received IPv4 packets byte by byte and gives one verdict per header.
//
// Channel   Signals                                  Transaction
// byte      byte_valid, byte_stall, byte_item        one packet byte, last mark
// result    result_valid, result_stall, result_item  one header verdict
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data one address register write
//
// One byte is taken every cycle while byte_stall is low; the parser does one
// 16-bit add with carry fold per byte pair. A header entry is queued on the
// edge that takes the last header byte; its verdict enters the result register.
// The byte channel stalls only while the queue holds QUEUE_DEPTH headers.
// Reset clears the parser's index and sum, the queue, result_valid and the own
// address, sets the broadcast address to ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "ipv4_receive_header_filter_unit_macros.svh"

module ipv4_receive_header_filter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_stall,
  input  ihf_pkg::byte_item_t             byte_item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output ihf_pkg::result_item_t           result_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ihf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  logic                   push;
  ihf_pkg::header_entry_t push_entry;
  ihf_pkg::header_entry_t head;
  logic                   head_valid;
  logic                   queue_full;
  logic                   pop;

  assign cfg_ready = 1'b1;

  ihf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .queue_full (queue_full),
    .byte_stall (byte_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  ihf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  ihf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

  `IHF_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !queue_full)
  `IHF_ASSERT_NEXT(a_pop_loads_result, clk, rst, pop, result_valid)
  `IHF_ASSERT_IMPLIES(a_truncated_zero, clk, rst, result_valid && (result_item.verdict == ihf_pkg::VERDICT_TRUNCATED), (result_item.source_address == '0) && (result_item.header_bytes == '0) && (result_item.ttl_after == '0))
  `IHF_ASSERT_IMPLIES(a_header_length, clk, rst, result_valid && (result_item.verdict != ihf_pkg::VERDICT_TRUNCATED), (result_item.header_bytes >= ihf_pkg::MIN_HEADER_BYTES) && (result_item.header_bytes[1:0] == 2'b00))

endmodule
